// ===== design/ivs_pkg.sv =====
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared types for the indexed vector store: beat payloads, action and
// status codes, controller states, and controller/datapath command and flag
// groups.
// ----------------------------------------------------------------------------
package ivs_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_ERASE  = 3'd3,
        ACT_READ   = 3'd4,
        ACT_RESIZE = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         position;
        logic signed [31:0] value;
        logic [8:0]         target_size;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        status_t            status;
        logic [8:0]         element_count;
        logic               is_empty;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_FLUSH_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_FLUSH_DN,
        S_FILL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic shift_up;
        logic shift_dn;
        logic fill;
        logic place;
        logic shrink;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic go_up;
        logic go_dn;
        logic go_fill;
        logic at_pos;
        logic at_top;
        logic out_free;
    } flag_t;

endpackage

// ===== design/ivs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ivs_ctrl
// Operation sequencer: latches a beat, decodes it, steps the shift or fill
// loop one entry per cycle, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ivs_ctrl
    import ivs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  flag_t flags,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (flags.go_up)
                begin
                    state_next = S_SHIFT_UP;
                end
                else if (flags.go_dn)
                begin
                    state_next = S_SHIFT_DN;
                end
                else if (flags.go_fill)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_UP:
            begin
                cmd.shift_up = 1'b1;
                if (flags.at_pos)
                begin
                    state_next = S_FLUSH_UP;
                end
            end
            S_FLUSH_UP:
            begin
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_DONE;
            end
            S_SHIFT_DN:
            begin
                cmd.shift_dn = 1'b1;
                if (flags.at_top)
                begin
                    state_next = S_FLUSH_DN;
                end
            end
            S_FLUSH_DN:
            begin
                cmd.shrink = 1'b1;
                state_next = S_DONE;
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (flags.at_top)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (flags.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ivs_datapath.sv =====
// ----------------------------------------------------------------------------
// ivs_datapath
// Element memory (one write, one registered read port), element count,
// loop index, decode of the latched beat, and the output register.
// ----------------------------------------------------------------------------
module ivs_datapath
    import ivs_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  cmd_t  cmd,
    input  logic  rsp_stall,
    output flag_t flags,
    output logic  rsp_valid,
    output rsp_t  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 9) ? CW : 9;

    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    req_t                  item_reg,      item_next;
    logic [CW-1:0]         count_reg,     count_next;
    logic [AW-1:0]         idx_reg,       idx_next;
    status_t               status_reg,    status_next;
    logic                  rd_ok_reg,     rd_ok_next;
    logic                  rd_oob_reg,    rd_oob_next;
    logic                  wp_valid_reg,  wp_valid_next;
    logic [AW-1:0]         wp_addr_reg,   wp_addr_next;
    logic [ELEM_WIDTH-1:0] rdata_reg;
    rsp_t                  rsp_reg,       rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic [XW-1:0]         cnt_x, pos_x, tgt_x, dep_x, idx_x, tgt_c;
    logic                  full, pos_in, tgt_sat;
    logic                  push_ok, pop_ok, ins_ok, ers_ok, ers_shift, rd_ok, rd_oob;
    logic                  rsz, grow;
    status_t               dec_status;
    logic [ELEM_WIDTH-1:0] elem_val;
    logic signed [63:0]    rext;

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [ELEM_WIDTH-1:0] wdata;

    assign cnt_x   = XW'(count_reg);
    assign pos_x   = XW'(item_reg.position);
    assign tgt_x   = XW'(item_reg.target_size);
    assign dep_x   = XW'(DEPTH);
    assign idx_x   = XW'(idx_reg);
    assign full    = (cnt_x == dep_x);
    assign pos_in  = (pos_x < cnt_x);
    assign tgt_sat = (tgt_x > dep_x);
    assign tgt_c   = tgt_sat ? dep_x : tgt_x;

    assign elem_val = ELEM_WIDTH'(64'(item_reg.value));
    assign rext     = 64'($signed(rdata_reg));

    always_comb
    begin
        dec_status = ST_DONE;
        push_ok    = 1'b0;
        pop_ok     = 1'b0;
        ins_ok     = 1'b0;
        ers_ok     = 1'b0;
        rd_ok      = 1'b0;
        rd_oob     = 1'b0;
        rsz        = 1'b0;
        case (item_reg.action)
            ACT_PUSH:
            begin
                if (full)
                begin
                    dec_status = ST_SATURATED;
                end
                else
                begin
                    push_ok = 1'b1;
                end
            end
            ACT_POP:
            begin
                if (cnt_x == '0)
                begin
                    dec_status = ST_IGNORED;
                end
                else
                begin
                    pop_ok = 1'b1;
                end
            end
            ACT_INSERT:
            begin
                if (!pos_in)
                begin
                    dec_status = ST_IGNORED;
                end
                else if (full)
                begin
                    dec_status = ST_SATURATED;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            ACT_ERASE:
            begin
                if (!pos_in)
                begin
                    dec_status = ST_IGNORED;
                end
                else
                begin
                    ers_ok = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (pos_in)
                begin
                    rd_ok = 1'b1;
                end
                else
                begin
                    rd_oob     = 1'b1;
                    dec_status = ST_IGNORED;
                end
            end
            ACT_RESIZE:
            begin
                rsz = 1'b1;
                if (tgt_sat)
                begin
                    dec_status = ST_SATURATED;
                end
            end
            default:
            begin
                dec_status = ST_IGNORED;
            end
        endcase
    end

    assign ers_shift = ers_ok && ((pos_x + XW'(1)) < cnt_x);
    assign grow      = rsz && (tgt_c > cnt_x);

    assign flags.go_up    = ins_ok;
    assign flags.go_dn    = ers_shift;
    assign flags.go_fill  = grow;
    assign flags.at_pos   = (idx_x == pos_x);
    assign flags.at_top   = ((idx_x + XW'(1)) == cnt_x);
    assign flags.out_free = !rsp_valid_reg || !rsp_stall;

    // pending shift write lands in the cycle after its read
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = '0;
        if (wp_valid_reg)
        begin
            we    = 1'b1;
            waddr = wp_addr_reg;
            wdata = rdata_reg;
        end
        else if (cmd.decode && push_ok)
        begin
            we    = 1'b1;
            waddr = AW'(cnt_x);
            wdata = elem_val;
        end
        else if (cmd.place)
        begin
            we    = 1'b1;
            waddr = AW'(pos_x);
            wdata = elem_val;
        end
        else if (cmd.fill)
        begin
            we    = 1'b1;
            waddr = idx_reg;
            wdata = '0;
        end
    end

    assign re    = (cmd.decode && rd_ok) || cmd.shift_up || cmd.shift_dn;
    assign raddr = (cmd.shift_up || cmd.shift_dn) ? idx_reg : AW'(pos_x);

    always_comb
    begin
        item_next      = cmd.load ? req : item_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        rd_ok_next     = rd_ok_reg;
        rd_oob_next    = rd_oob_reg;
        wp_valid_next  = cmd.shift_up || cmd.shift_dn;
        wp_addr_next   = cmd.shift_up ? (idx_reg + AW'(1)) : (idx_reg - AW'(1));
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (cmd.decode)
        begin
            status_next = dec_status;
            rd_ok_next  = rd_ok;
            rd_oob_next = rd_oob;
            if (push_ok)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (pop_ok || (ers_ok && !ers_shift))
            begin
                count_next = count_reg - CW'(1);
            end
            else if (rsz)
            begin
                count_next = CW'(tgt_c);
            end
            if (ins_ok)
            begin
                idx_next = AW'(cnt_x - XW'(1));
            end
            else if (ers_shift)
            begin
                idx_next = AW'(pos_x + XW'(1));
            end
            else
            begin
                idx_next = AW'(cnt_x);
            end
        end

        if (cmd.shift_up)
        begin
            idx_next = idx_reg - AW'(1);
        end
        if (cmd.shift_dn || cmd.fill)
        begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.place)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.shrink)
        begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.emit)
        begin
            rsp_next.read_value    = rd_ok_reg  ? rext[31:0] :
                                     rd_oob_reg ? '1 : '0;
            rsp_next.status        = status_reg;
            rsp_next.element_count = cnt_x[8:0];
            rsp_next.is_empty      = (cnt_x == '0);
            rsp_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wp_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            wp_valid_reg  <= wp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        rd_ok_reg   <= rd_ok_next;
        rd_oob_reg  <= rd_oob_next;
        wp_addr_reg <= wp_addr_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== design/indexed_vector_store.sv =====
// ----------------------------------------------------------------------------
// indexed_vector_store
// Ordered store of up to DEPTH signed elements with push, pop, insert,
// erase, read and resize; one result beat per request beat.
//
// Channels: req (valid/stall) carries action, position, value, target_size;
// rsp (valid/stall) carries read_value, status, element_count, is_empty.
// One request is worked on at a time; req_stall is high from the beat
// after acceptance until its result is loaded into the output register.
// Insert, erase (unless of the last element) and a growing resize step
// through the element memory (one read and one write port) one entry per
// cycle, so their time grows with the entries moved; the next request is
// accepted as its predecessor's result appears. A new request is accepted
// while a previous result waits in the output register; its result is
// held back until the receiver lets that go. Reset clears the count and
// both valids; memory is not cleared.
// ----------------------------------------------------------------------------
module indexed_vector_store
    import ivs_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t  cmd;
    flag_t flags;

    ivs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .flags     (flags),
        .cmd       (cmd),
        .busy      (req_stall)
    );

    ivs_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .flags     (flags),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while another is in flight");

    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared without a request in progress");

    a_place_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> !$past(cmd.shift_up))
        else $error("insert write collides with pending shift write");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for indexed_vector_store. A behavioral copy of the
// store predicts every result beat. The checker compares each result beat
// field by field against the oldest prediction. Directed tasks cover the
// empty, full and range corner cases. Random phases mix all operations
// under varied request gaps and result stalls. A long result hold-off
// fills the block, and the sender pauses between phases until all
// results are in.
// ----------------------------------------------------------------------------
module testbench;
    import ivs_pkg::*;

    localparam int          DEPTH        = 256;
    localparam int          CYCLE_LIMIT  = 4000000;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [2:0]  ACT_UNUSED_6 = 3'd6;
    localparam logic [2:0]  ACT_UNUSED_7 = 3'd7;
    localparam logic [31:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] VAL_ALL_ONES = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Store mirror
    logic signed [31:0] mirror_mem [DEPTH];
    int unsigned        mirror_count;

    rsp_t expected_rsp [$];
    int   error_count;
    int   cycle_count;
    int   req_gap_pct;
    int   rsp_stall_pct;
    int   hold_off_left;

    indexed_vector_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short, a few long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic req_t make_op(logic [2:0] act, int pos, logic [31:0] val, int size);
        req_t op;
        op.action      = act;
        op.position    = pos[7:0];
        op.value       = val;
        op.target_size = size[8:0];
        return op;
    endfunction

    // Applies one operation to the mirror and returns its result beat
    function automatic rsp_t apply_to_mirror(req_t op);
        rsp_t        res;
        int unsigned pos;
        int unsigned target;
        int unsigned i;
        res.read_value = '0;
        res.status     = ST_DONE;
        pos            = op.position;
        target         = op.target_size;
        case (op.action)
            ACT_PUSH:
            begin
                if (mirror_count < DEPTH)
                begin
                    mirror_mem[mirror_count] = op.value;
                    mirror_count++;
                end
                else
                    res.status = ST_SATURATED;
            end
            ACT_POP:
            begin
                if (mirror_count > 0)
                    mirror_count--;
                else
                    res.status = ST_IGNORED;
            end
            ACT_INSERT:
            begin
                if (pos >= mirror_count)
                    res.status = ST_IGNORED;
                else if (mirror_count >= DEPTH)
                    res.status = ST_SATURATED;
                else
                begin
                    for (i = mirror_count; i > pos; i--)
                        mirror_mem[i] = mirror_mem[i - 1];
                    mirror_mem[pos] = op.value;
                    mirror_count++;
                end
            end
            ACT_ERASE:
            begin
                if (pos >= mirror_count)
                    res.status = ST_IGNORED;
                else
                begin
                    for (i = pos; i + 1 < mirror_count; i++)
                        mirror_mem[i] = mirror_mem[i + 1];
                    mirror_count--;
                end
            end
            ACT_READ:
            begin
                if (pos < mirror_count)
                    res.read_value = mirror_mem[pos];
                else
                begin
                    res.read_value = -1;
                    res.status     = ST_IGNORED;
                end
            end
            ACT_RESIZE:
            begin
                if (target > DEPTH)
                begin
                    target     = DEPTH;
                    res.status = ST_SATURATED;
                end
                for (i = mirror_count; i < target; i++)
                    mirror_mem[i] = '0;
                mirror_count = target;
            end
            default:
                res.status = ST_IGNORED;
        endcase
        res.element_count = mirror_count[8:0];
        res.is_empty      = (mirror_count == 0);
        return res;
    endfunction

    // Valid stays high after the beat so a back-to-back item needs no toggle
    task automatic send_op(input req_t op);
        int gap;
        gap = ($urandom_range(99) < req_gap_pct) ? idle_len() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= op;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsp.insert(expected_rsp.size(), apply_to_mirror(op));
    endtask

    task automatic wait_all_results();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic req_t random_op();
        int          pick;
        int          grow_w;
        int          pos;
        int          size;
        logic [31:0] val;
        logic [2:0]  act;
        grow_w = (mirror_count > 160) ? 10 : 22;
        pick   = $urandom_range(2 * grow_w + 59);
        if (pick < grow_w)
            act = ACT_PUSH;
        else if (pick < 2 * grow_w)
            act = ACT_INSERT;
        else if (pick < 2 * grow_w + 12)
            act = ACT_POP;
        else if (pick < 2 * grow_w + 30)
            act = ACT_ERASE;
        else if (pick < 2 * grow_w + 50)
            act = ACT_READ;
        else if (pick < 2 * grow_w + 58)
            act = ACT_RESIZE;
        else
            act = $urandom_range(1) ? ACT_UNUSED_7 : ACT_UNUSED_6;

        if (mirror_count > 0 && $urandom_range(99) < 85)
            pos = $urandom_range(mirror_count - 1);
        else
            pos = $urandom_range(255);

        case ($urandom_range(39))
            0:       val = VAL_MAX;
            1:       val = VAL_MIN;
            2:       val = '0;
            3:       val = VAL_ALL_ONES;
            default: val = $urandom;
        endcase

        pick = $urandom_range(99);
        if (pick < 70)
        begin
            size = int'(mirror_count) + $urandom_range(16) - 8;
            if (size < 0)
                size = 0;
            if (size > DEPTH)
                size = DEPTH;
        end
        else if (pick < 90)
            size = $urandom_range(64);
        else if (pick < 98)
            size = $urandom_range(DEPTH);
        else
            size = $urandom_range(511, DEPTH + 1);
        return make_op(act, pos, val, size);
    endfunction

    task automatic test_empty_store();
        send_op(make_op(ACT_POP, 0, '0, 0));
        send_op(make_op(ACT_ERASE, 0, '0, 0));
        send_op(make_op(ACT_INSERT, 0, VAL_MAX, 0));
        send_op(make_op(ACT_READ, 0, '0, 0));
        send_op(make_op(ACT_UNUSED_6, 255, VAL_ALL_ONES, 511));
        send_op(make_op(ACT_UNUSED_7, 0, '0, 0));
        wait_all_results();
    endtask

    task automatic test_push_insert_read();
        send_op(make_op(ACT_PUSH, 0, VAL_MAX, 0));
        send_op(make_op(ACT_PUSH, 255, VAL_MIN, 511));
        send_op(make_op(ACT_PUSH, 0, VAL_ALL_ONES, 0));
        send_op(make_op(ACT_INSERT, 0, 32'h1234_5678, 0));
        send_op(make_op(ACT_READ, 0, '0, 0));
        send_op(make_op(ACT_READ, 4, '0, 0));
        wait_all_results();
    endtask

    task automatic test_erase();
        // last element, then the head
        send_op(make_op(ACT_ERASE, 3, '0, 0));
        send_op(make_op(ACT_ERASE, 0, '0, 0));
        wait_all_results();
    endtask

    task automatic test_resize();
        send_op(make_op(ACT_RESIZE, 0, '0, 2));
        send_op(make_op(ACT_RESIZE, 0, '0, 10));
        send_op(make_op(ACT_READ, 9, '0, 0));
        send_op(make_op(ACT_RESIZE, 0, '0, 1));
        wait_all_results();
    endtask

    task automatic test_full_store();
        send_op(make_op(ACT_RESIZE, 0, '0, DEPTH));
        send_op(make_op(ACT_PUSH, 0, VAL_MIN, 0));
        send_op(make_op(ACT_INSERT, 0, VAL_MAX, 0));
        send_op(make_op(ACT_READ, 255, '0, 0));
        send_op(make_op(ACT_ERASE, 255, '0, 0));
        send_op(make_op(ACT_RESIZE, 0, '0, 511));
        send_op(make_op(ACT_RESIZE, 0, '0, 0));
        wait_all_results();
    endtask

    // Result side held off; the block fills and stalls its input
    task automatic test_result_hold_off();
        int n;
        req_gap_pct   = 0;
        hold_off_left = HOLD_CYCLES;
        for (n = 0; n < 12; n++)
            send_op(random_op());
        wait_all_results();
    endtask

    task automatic test_random_mix(input int n_ops, input int gap_pct, input int stall_pct);
        int n;
        req_gap_pct   = gap_pct;
        rsp_stall_pct = stall_pct;
        for (n = 0; n < n_ops; n++)
            send_op(random_op());
        wait_all_results();
    endtask

    initial
    begin : stimulus
        rst_n         = 1'b0;
        req_valid    <= 1'b0;
        req          <= '0;
        mirror_count  = 0;
        error_count   = 0;
        req_gap_pct   = 30;
        rsp_stall_pct = 30;
        hold_off_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_push_insert_read();
        test_erase();
        test_resize();
        test_full_store();
        test_random_mix(600, 30, 30);
        test_result_hold_off();
        test_random_mix(400, 0, 0);
        test_random_mix(500, 60, 60);
        test_random_mix(500, 0, 50);

        wait_all_results();
        repeat (DEPTH + 10) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            $error("%0d result beats never arrived", expected_rsp.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : rsp_stall_drive
        int stall_left;
        stall_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if ($urandom_range(99) < rsp_stall_pct)
            begin
                stall_left = idle_len() - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin : result_check
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("result beat with none expected");
                    error_count++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, rsp.read_value);
                        error_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.element_count !== want.element_count)
                    begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, rsp.element_count);
                        error_count++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, rsp.is_empty);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
